[rtl/itl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_pkg: shared types for the interval table lookup unit
// Command and status codes, sequencer states and the "no selection" code.
// ----------------------------------------------------------------------------
package itl_pkg;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_LOOKUP = 3'd2,
		CMD_GET    = 3'd3,
		CMD_CLEAR  = 3'd4,
		CMD_SELECT = 3'd5,
		CMD_RSVD6  = 3'd6,
		CMD_RSVD7  = 3'd7
	} itl_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_MISS  = 2'd3
	} itl_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GET,
		S_LOOK,
		S_SHIFT,
		S_PUT
	} itl_state_t;

	// selection output when nothing is selected (-1)
	localparam logic signed [6:0] SEL_NONE = -7'sd1;

endpackage

[rtl/itl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module itl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/interval_table_lookup_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_lookup_unit: table of closed time intervals with selection
// Add, remove, lookup by time, get, clear and select over a table of
// TABLE_DEPTH [start, end] intervals held in one memory.
// ----------------------------------------------------------------------------
// Usage: the unit takes one item at a time and returns exactly one result
// item for it. Add, clear, select, the unused codes and any item refused for
// a full table or an index at or beyond the count go from the execute state
// straight to the result state; get reads its entry between the two. Lookup
// walks the table from entry 0; remove shifts the later entries down one by
// one. Both are paced by the single read port of the interval memory, which
// is read one entry per cycle with the compare or write-back pipelined behind
// each read. A stall on the result channel holds the sequencer in the result
// state until the output register is free. The next item is accepted as soon
// as the sequencer is back in idle, even while the previous result is still
// held on the output. No clearing pass is needed after reset: entries at or
// above the count are never read.
// ----------------------------------------------------------------------------
module interval_table_lookup_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int TIME_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [31:0]        start_ms,
	input  logic [31:0]        end_ms,
	input  logic [31:0]        query_ms,
	input  logic [5:0]         entry_index,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [5:0]         hit_index,
	output logic [31:0]        hit_start_ms,
	output logic [31:0]        hit_end_ms,
	output logic [6:0]         entry_count,
	output logic signed [6:0]  selected
);

	localparam int IW = $clog2(TABLE_DEPTH);        // entry address
	localparam int CW = $clog2(TABLE_DEPTH + 1);    // count, 0..TABLE_DEPTH
	localparam int XW = (CW > 6) ? CW : 6;          // index compare width
	localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int RW = 2 * TW;                     // {start, end} per entry

	// sequencer and table state
	itl_pkg::itl_state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          sel_vld_q, sel_vld_d;
	logic [IW-1:0] sel_idx_q, sel_idx_d;
	logic          rd_v_s1, rd_v_d;
	logic          out_valid_q, out_valid_d;

	// latched item
	itl_pkg::itl_cmd_t cmd_q, cmd_d;
	logic [TW-1:0] s_q, s_d, e_q, e_d, qry_q, qry_d;
	logic [5:0]    idx_q, idx_d;

	// walk pointer and read pipeline address
	logic [CW-1:0] ptr_q, ptr_d;
	logic [IW-1:0] addr_s1, addr_d;

	// pending result
	itl_pkg::itl_status_t res_status_q, res_status_d;
	logic [IW-1:0] res_idx_q, res_idx_d;
	logic [TW-1:0] res_s_q, res_s_d, res_e_q, res_e_d;

	// output register
	itl_pkg::itl_status_t out_status_q, out_status_d;
	logic [5:0]  out_idx_q, out_idx_d;
	logic [31:0] out_s_q, out_s_d, out_e_q, out_e_d;
	logic [6:0]  out_cnt_q, out_cnt_d;
	logic signed [6:0] out_sel_q, out_sel_d;

	// memory port
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	logic [TW-1:0] rd_s, rd_e;
	logic          hit;
	logic [XW-1:0] idx_ext, cnt_ext;
	logic          idx_ok;
	logic [CW-1:0] ptr_nx;

	itl_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign rd_s    = ram_rdata[RW-1:TW];
	assign rd_e    = ram_rdata[TW-1:0];
	// closed interval test; an inverted interval never matches
	assign hit     = (qry_q >= rd_s) && (qry_q <= rd_e);
	assign idx_ext = XW'(idx_q);
	assign cnt_ext = XW'(count_q);
	assign idx_ok  = idx_ext < cnt_ext;
	assign ptr_nx  = ptr_q + 1'b1;

	// next state, memory control and result datapath
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		sel_vld_d    = sel_vld_q;
		sel_idx_d    = sel_idx_q;
		rd_v_d       = rd_v_s1;
		out_valid_d  = out_valid_q && out_stall;
		cmd_d        = cmd_q;
		s_d          = s_q;
		e_d          = e_q;
		qry_d        = qry_q;
		idx_d        = idx_q;
		ptr_d        = ptr_q;
		addr_d       = addr_s1;
		res_status_d = res_status_q;
		res_idx_d    = res_idx_q;
		res_s_d      = res_s_q;
		res_e_d      = res_e_q;
		out_status_d = out_status_q;
		out_idx_d    = out_idx_q;
		out_s_d      = out_s_q;
		out_e_d      = out_e_q;
		out_cnt_d    = out_cnt_q;
		out_sel_d    = out_sel_q;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = '0;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		in_stall     = (state_q != itl_pkg::S_IDLE);

		case (state_q)
			itl_pkg::S_IDLE: begin
				// take the item; times are cut to the stored width
				if (in_valid) begin
					cmd_d   = itl_pkg::itl_cmd_t'(cmd);
					s_d     = TW'(start_ms);
					e_d     = TW'(end_ms);
					qry_d   = TW'(query_ms);
					idx_d   = entry_index;
					state_d = itl_pkg::S_EXEC;
				end
			end
			itl_pkg::S_EXEC: begin
				res_status_d = itl_pkg::STAT_OK;
				res_idx_d    = '0;
				res_s_d      = '0;
				res_e_d      = '0;
				state_d      = itl_pkg::S_PUT;
				case (cmd_q)
					itl_pkg::CMD_ADD: begin
						if (count_q == CW'(TABLE_DEPTH)) begin
							res_status_d = itl_pkg::STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = IW'(count_q);
							ram_wdata = {s_q, e_q};
							count_d   = count_q + 1'b1;
							res_idx_d = IW'(count_q);
						end
					end
					itl_pkg::CMD_REMOVE: begin
						if (!idx_ok) begin
							res_status_d = itl_pkg::STAT_RANGE;
						end else begin
							// drop or move down the selection now; shift entries next
							if (sel_vld_q && (sel_idx_q == IW'(idx_ext))) begin
								sel_vld_d = 1'b0;
							end else if (sel_vld_q && (sel_idx_q > IW'(idx_ext))) begin
								sel_idx_d = sel_idx_q - 1'b1;
							end
							ptr_d   = CW'(idx_ext);
							rd_v_d  = 1'b0;
							state_d = itl_pkg::S_SHIFT;
						end
					end
					itl_pkg::CMD_LOOKUP: begin
						ptr_d   = '0;
						rd_v_d  = 1'b0;
						state_d = itl_pkg::S_LOOK;
					end
					itl_pkg::CMD_GET: begin
						if (!idx_ok) begin
							res_status_d = itl_pkg::STAT_RANGE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = IW'(idx_ext);
							addr_d    = IW'(idx_ext);
							state_d   = itl_pkg::S_GET;
						end
					end
					itl_pkg::CMD_CLEAR: begin
						count_d   = '0;
						sel_vld_d = 1'b0;
					end
					itl_pkg::CMD_SELECT: begin
						if (!idx_ok) begin
							res_status_d = itl_pkg::STAT_RANGE;
						end else begin
							sel_vld_d = 1'b1;
							sel_idx_d = IW'(idx_ext);
						end
					end
					default: begin
					end
				endcase
			end
			itl_pkg::S_GET: begin
				res_idx_d = addr_s1;
				res_s_d   = rd_s;
				res_e_d   = rd_e;
				state_d   = itl_pkg::S_PUT;
			end
			itl_pkg::S_LOOK: begin
				// compare last read entry, issue next read below the count
				if (rd_v_s1 && hit) begin
					res_idx_d = addr_s1;
					res_s_d   = rd_s;
					res_e_d   = rd_e;
					rd_v_d    = 1'b0;
					state_d   = itl_pkg::S_PUT;
				end else if (ptr_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = IW'(ptr_q);
					addr_d    = IW'(ptr_q);
					rd_v_d    = 1'b1;
					ptr_d     = ptr_nx;
				end else begin
					rd_v_d = 1'b0;
					if (!rd_v_s1) begin
						res_status_d = itl_pkg::STAT_MISS;
						state_d      = itl_pkg::S_PUT;
					end
				end
			end
			itl_pkg::S_SHIFT: begin
				// write back entry i+1 into i while reading entry i+2
				if (rd_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = ram_rdata;
				end
				if (ptr_nx < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = IW'(ptr_nx);
					addr_d    = IW'(ptr_q);
					rd_v_d    = 1'b1;
					ptr_d     = ptr_nx;
				end else begin
					rd_v_d = 1'b0;
					if (!rd_v_s1) begin
						count_d = count_q - 1'b1;
						state_d = itl_pkg::S_PUT;
					end
				end
			end
			itl_pkg::S_PUT: begin
				// hold the result until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_idx_d    = 6'(res_idx_q);
					out_s_d      = 32'(res_s_q);
					out_e_d      = 32'(res_e_q);
					out_cnt_d    = 7'(count_q);
					out_sel_d    = sel_vld_q ? 7'(sel_idx_q) : itl_pkg::SEL_NONE;
					state_d      = itl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = itl_pkg::S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sel_vld_q   <= 1'b0;
			sel_idx_q   <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			sel_vld_q   <= sel_vld_d;
			sel_idx_q   <= sel_idx_d;
			rd_v_s1     <= rd_v_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		s_q          <= s_d;
		e_q          <= e_d;
		qry_q        <= qry_d;
		idx_q        <= idx_d;
		ptr_q        <= ptr_d;
		addr_s1      <= addr_d;
		res_status_q <= res_status_d;
		res_idx_q    <= res_idx_d;
		res_s_q      <= res_s_d;
		res_e_q      <= res_e_d;
		out_status_q <= out_status_d;
		out_idx_q    <= out_idx_d;
		out_s_q      <= out_s_d;
		out_e_q      <= out_e_d;
		out_cnt_q    <= out_cnt_d;
		out_sel_q    <= out_sel_d;
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign hit_index    = out_idx_q;
	assign hit_start_ms = out_s_q;
	assign hit_end_ms   = out_e_q;
	assign entry_count  = out_cnt_q;
	assign selected     = out_sel_q;

	// count never runs past the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// a live selection always points at a valid entry
	a_sel_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		sel_vld_q |-> (CW'(sel_idx_q) < count_q))
		else $error("selection beyond entry count");

	// a new result appears only out of the result state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || !out_stall) && out_valid_d |-> state_q == itl_pkg::S_PUT)
		else $error("result loaded outside result state");

	// memory writes happen only for add or the remove shift
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == itl_pkg::S_EXEC && cmd_q == itl_pkg::CMD_ADD)
			|| (state_q == itl_pkg::S_SHIFT && rd_v_s1))
		else $error("unexpected table write");

endmodule

[tb/interval_table_lookup_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_lookup_unit_test: self-checking bench for the interval table
// Drives add, remove, lookup, get, clear, select and the unused codes through
// the valid/stall input channel. A shadow copy of the interval table predicts
// the one result item of every accepted command, and the monitor compares
// each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module interval_table_lookup_unit_test;

	localparam int DEPTH           = 64;
	localparam int RANDOM_ITEMS    = 1300;
	// receiver hold-off that backs the unit up into its input channel
	localparam int PRESSURE_AT     = 500;
	localparam int PRESSURE_CYCLES = 400;
	// cycles without any handshake before the run is declared hung
	localparam int IDLE_LIMIT      = 3000;
	// tail hold sized to cover a lookup that walks all DEPTH entries
	localparam int TAIL_CYCLES     = DEPTH + 16;

	typedef struct {
		itl_pkg::itl_cmd_t cmd;
		logic [31:0]       start_ms;
		logic [31:0]       end_ms;
		logic [31:0]       query_ms;
		logic [5:0]        entry_index;
	} cmd_item_t;

	typedef struct {
		itl_pkg::itl_status_t status;
		logic [5:0]           hit_index;
		logic [31:0]          hit_start_ms;
		logic [31:0]          hit_end_ms;
		logic [6:0]           entry_count;
		logic signed [6:0]    selected;
	} reply_t;

	typedef enum {PH_FILL, PH_MIX, PH_DRAIN} mix_phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         cmd = '0;
	logic [31:0]        start_ms = '0;
	logic [31:0]        end_ms = '0;
	logic [31:0]        query_ms = '0;
	logic [5:0]         entry_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [5:0]         hit_index;
	logic [31:0]        hit_start_ms;
	logic [31:0]        hit_end_ms;
	logic [6:0]         entry_count;
	logic signed [6:0]  selected;

	// commands waiting to be offered, and results owed by the unit
	cmd_item_t pending_cmds[$];
	reply_t    replies_due[$];

	// shadow of the interval table
	logic [31:0] shadow_start[DEPTH];
	logic [31:0] shadow_end[DEPTH];
	int          shadow_count = 0;
	int          shadow_sel = -1;

	int items_total = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int error_count = 0;
	int idle_cycles = 0;

	// generation-side view of the count, used only to aim entry indexes
	int gen_count = 0;

	interval_table_lookup_unit dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.cmd,
		.start_ms,
		.end_ms,
		.query_ms,
		.entry_index,
		.out_valid,
		.out_stall,
		.status,
		.hit_index,
		.hit_start_ms,
		.hit_end_ms,
		.entry_count,
		.selected
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predict the result of one command and advance the shadow table
	// ------------------------------------------------------------------------
	function automatic reply_t execute_cmd(input cmd_item_t it);
		reply_t r;
		int     i;
		int     pos;
		bit     found;
		r.status       = itl_pkg::STAT_OK;
		r.hit_index    = '0;
		r.hit_start_ms = '0;
		r.hit_end_ms   = '0;
		pos            = int'(it.entry_index);
		found          = 1'b0;
		case (it.cmd)
			itl_pkg::CMD_ADD: begin
				if (shadow_count >= DEPTH) begin
					r.status = itl_pkg::STAT_FULL;
				end else begin
					shadow_start[shadow_count] = it.start_ms;
					shadow_end[shadow_count]   = it.end_ms;
					r.hit_index                = 6'(shadow_count);
					shadow_count++;
				end
			end
			itl_pkg::CMD_REMOVE: begin
				if (pos >= shadow_count) begin
					r.status = itl_pkg::STAT_RANGE;
				end else begin
					// close the gap: shift every later entry down by one
					for (i = pos; i + 1 < shadow_count; i++) begin
						shadow_start[i] = shadow_start[i + 1];
						shadow_end[i]   = shadow_end[i + 1];
					end
					shadow_count--;
					if (shadow_sel == pos)
						shadow_sel = -1;
					else if (shadow_sel > pos)
						shadow_sel--;
				end
			end
			itl_pkg::CMD_LOOKUP: begin
				// first entry whose closed interval holds the time wins
				for (i = 0; i < shadow_count && !found; i++) begin
					if (it.query_ms >= shadow_start[i] && it.query_ms <= shadow_end[i]) begin
						found          = 1'b1;
						r.hit_index    = 6'(i);
						r.hit_start_ms = shadow_start[i];
						r.hit_end_ms   = shadow_end[i];
					end
				end
				if (!found)
					r.status = itl_pkg::STAT_MISS;
			end
			itl_pkg::CMD_GET: begin
				if (pos >= shadow_count) begin
					r.status = itl_pkg::STAT_RANGE;
				end else begin
					r.hit_index    = it.entry_index;
					r.hit_start_ms = shadow_start[pos];
					r.hit_end_ms   = shadow_end[pos];
				end
			end
			itl_pkg::CMD_CLEAR: begin
				shadow_count = 0;
				shadow_sel   = int'(itl_pkg::SEL_NONE);
			end
			itl_pkg::CMD_SELECT: begin
				if (pos >= shadow_count)
					r.status = itl_pkg::STAT_RANGE;
				else
					shadow_sel = pos;
			end
			default: begin
				// unused codes change nothing
			end
		endcase
		r.entry_count = 7'(shadow_count);
		r.selected    = 7'(shadow_sel);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Queue one command and track the count it leaves behind
	// ------------------------------------------------------------------------
	task automatic push_item(input itl_pkg::itl_cmd_t c, input logic [31:0] s,
			input logic [31:0] e, input logic [31:0] q, input logic [5:0] idx);
		cmd_item_t it;
		it.cmd         = c;
		it.start_ms    = s;
		it.end_ms      = e;
		it.query_ms    = q;
		it.entry_index = idx;
		pending_cmds.push_back(it);
		items_total++;
		case (c)
			itl_pkg::CMD_ADD:    if (gen_count < DEPTH) gen_count++;
			itl_pkg::CMD_REMOVE: if (int'(idx) < gen_count) gen_count--;
			itl_pkg::CMD_CLEAR:  gen_count = 0;
			default:             ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0]       seen_lo[DEPTH];
		logic [31:0]       seen_hi[DEPTH];
		int                seen_n;
		int                seen_wr;
		mix_phase_t        phase;
		int                phase_left;
		int                n_random;
		int                roll;
		int                j;
		logic [31:0]       cluster_ms;
		logic [31:0]       s;
		logic [31:0]       e;
		logic [31:0]       q;
		logic [5:0]        idx;
		itl_pkg::itl_cmd_t c;

		// Directed: empty table, extreme intervals, reversed interval,
		// selection tracking across removes, unused codes, clear.
		push_item(itl_pkg::CMD_GET,    0, 0, 0, 0);
		push_item(itl_pkg::CMD_LOOKUP, 0, 0, $urandom, 0);
		push_item(itl_pkg::CMD_REMOVE, 0, 0, 0, 0);
		push_item(itl_pkg::CMD_SELECT, 0, 0, 0, 0);
		push_item(itl_pkg::CMD_ADD,    32'h0, 32'h0, 0, 0);
		push_item(itl_pkg::CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		push_item(itl_pkg::CMD_ADD,    100, 50, 0, 0);
		push_item(itl_pkg::CMD_ADD,    32'h0, 32'hFFFF_FFFF, 0, 0);
		push_item(itl_pkg::CMD_LOOKUP, 0, 0, 32'h0, 0);
		push_item(itl_pkg::CMD_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0);
		// the reversed entry holds 75 by neither bound, so entry 3 answers
		push_item(itl_pkg::CMD_LOOKUP, 0, 0, 75, 0);
		push_item(itl_pkg::CMD_GET,    0, 0, 0, 3);
		push_item(itl_pkg::CMD_GET,    0, 0, 0, 4);
		push_item(itl_pkg::CMD_GET,    0, 0, 0, 63);
		push_item(itl_pkg::CMD_SELECT, 0, 0, 0, 2);
		push_item(itl_pkg::CMD_REMOVE, 0, 0, 0, 1);
		push_item(itl_pkg::CMD_REMOVE, 0, 0, 0, 1);
		push_item(itl_pkg::CMD_SELECT, 0, 0, 0, 1);
		push_item(itl_pkg::CMD_REMOVE, 0, 0, 0, 0);
		push_item(itl_pkg::CMD_SELECT, 0, 0, 0, 63);
		push_item(itl_pkg::CMD_RSVD6,  $urandom, $urandom, $urandom, 6'($urandom));
		push_item(itl_pkg::CMD_RSVD7,  $urandom, $urandom, $urandom, 6'($urandom));
		push_item(itl_pkg::CMD_CLEAR,  0, 0, 0, 0);
		push_item(itl_pkg::CMD_LOOKUP, 0, 0, 32'h0, 0);
		push_item(itl_pkg::CMD_ADD,    32'hAAAA_AAAA, 32'h5555_5555, 0, 0);

		// Random: phases that fill, mix and drain the table. Queries mostly
		// land inside intervals already added so lookups find real hits.
		seen_n     = 0;
		seen_wr    = 0;
		phase_left = 0;
		n_random   = 0;
		phase      = PH_FILL;
		cluster_ms = $urandom;
		while (n_random < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				// open with a fill so the full table shows up early
				phase      = (n_random == 0) ? PH_FILL : mix_phase_t'($urandom_range(0, 2));
				phase_left = (phase == PH_FILL) ? $urandom_range(70, 120) : $urandom_range(30, 90);
				cluster_ms = $urandom;
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			case (phase)
				PH_FILL: begin
					if (roll < 80)      c = itl_pkg::CMD_ADD;
					else if (roll < 88) c = itl_pkg::CMD_LOOKUP;
					else if (roll < 93) c = itl_pkg::CMD_GET;
					else if (roll < 97) c = itl_pkg::CMD_SELECT;
					else                c = itl_pkg::CMD_REMOVE;
				end
				PH_MIX: begin
					if (roll < 25)      c = itl_pkg::CMD_ADD;
					else if (roll < 40) c = itl_pkg::CMD_REMOVE;
					else if (roll < 70) c = itl_pkg::CMD_LOOKUP;
					else if (roll < 83) c = itl_pkg::CMD_GET;
					else if (roll < 93) c = itl_pkg::CMD_SELECT;
					else if (roll < 95) c = itl_pkg::CMD_CLEAR;
					else if ($urandom_range(0, 1) != 0) c = itl_pkg::CMD_RSVD6;
					else                c = itl_pkg::CMD_RSVD7;
				end
				default: begin
					if (roll < 45)      c = itl_pkg::CMD_REMOVE;
					else if (roll < 65) c = itl_pkg::CMD_LOOKUP;
					else if (roll < 80) c = itl_pkg::CMD_GET;
					else if (roll < 95) c = itl_pkg::CMD_SELECT;
					else if (roll < 97) c = itl_pkg::CMD_ADD;
					else if ($urandom_range(0, 1) != 0) c = itl_pkg::CMD_RSVD6;
					else                c = itl_pkg::CMD_RSVD7;
				end
			endcase

			// interval: clustered and overlapping, wide, reversed or pinned
			roll = $urandom_range(0, 9);
			if (roll < 3) begin
				s = cluster_ms + $urandom_range(0, 2000);
				e = s + $urandom_range(0, 3000);
				if (e < s) e = 32'hFFFF_FFFF;
			end else if (roll < 6) begin
				s = $urandom;
				e = s + $urandom_range(0, 5000);
				if (e < s) e = 32'hFFFF_FFFF;
			end else if (roll == 6) begin
				s = $urandom;
				e = $urandom;
			end else if (roll == 7) begin
				s = $urandom | 32'h1;
				e = $urandom_range(s - 1, 0);
			end else if (roll == 8) begin
				s = 32'h0;
				e = $urandom;
			end else begin
				s = $urandom;
				e = 32'hFFFF_FFFF;
			end

			// query: inside a known interval, on its bounds, or anywhere
			roll = $urandom_range(0, 9);
			if (seen_n > 0 && roll < 8) begin
				j = $urandom_range(0, seen_n - 1);
				if (roll < 6)
					q = (seen_lo[j] <= seen_hi[j]) ? $urandom_range(seen_hi[j], seen_lo[j])
						: seen_lo[j];
				else if (roll == 6)
					q = seen_lo[j];
				else
					q = seen_hi[j];
			end else begin
				q = $urandom;
			end

			// index: mostly a live entry, sometimes anywhere in range
			if (gen_count > 0 && $urandom_range(0, 9) < 8)
				idx = 6'($urandom_range(0, gen_count - 1));
			else
				idx = 6'($urandom_range(0, 63));

			if (c == itl_pkg::CMD_ADD) begin
				seen_lo[seen_wr] = s;
				seen_hi[seen_wr] = e;
				seen_wr = (seen_wr + 1) % DEPTH;
				if (seen_n < DEPTH) seen_n++;
			end
			push_item(c, s, e, q, idx);
			n_random++;
		end

		// release reset once, on a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge, clear of the driver and monitor
		while (items_accepted < items_total || replies_due.size() != 0)
			@(negedge clk);
		// hold a little longer to catch any stray result
		repeat (TAIL_CYCLES) @(negedge clk);
		if (replies_due.size() != 0) begin
			$error("results still owed at end of run: %0d", replies_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("interval_table_lookup_unit test passed");
		else
			$display("interval_table_lookup_unit test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: offer queued commands with random gaps and idle-free bursts
	// ------------------------------------------------------------------------
	cmd_item_t cur_item;
	int        send_wait;
	int        send_burst;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			send_wait  = 0;
			send_burst = 0;
		end else begin
			// predict at the handshake, in acceptance order
			if (in_valid && !in_stall) begin
				replies_due.push_back(execute_cmd(cur_item));
				items_accepted++;
			end
			// the payload may only move once the current item is gone
			if (!in_valid || !in_stall) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cur_item    = pending_cmds.pop_front();
					cmd         <= cur_item.cmd;
					start_ms    <= cur_item.start_ms;
					end_ms      <= cur_item.end_ms;
					query_ms    <= cur_item.query_ms;
					entry_index <= cur_item.entry_index;
					in_valid    <= 1'b1;
					// draw the gap ahead of the next item
					if (send_burst > 0) begin
						send_burst--;
						send_wait = 0;
					end else begin
						send_wait = $urandom_range(0, 15);
						if ($urandom_range(0, 39) == 0)
							send_burst = $urandom_range(20, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: take results with random stalls, check against predictions
	// ------------------------------------------------------------------------
	reply_t want;
	int     recv_wait;
	int     recv_burst;
	int     hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			recv_wait  = 0;
			recv_burst = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("result item with no command outstanding: status %0d", status);
					error_count++;
				end else begin
					want = replies_due.pop_front();
					compare_field("status",       want.status,       status);
					compare_field("hit_index",    want.hit_index,    hit_index);
					compare_field("hit_start_ms", want.hit_start_ms, hit_start_ms);
					compare_field("hit_end_ms",   want.hit_end_ms,   hit_end_ms);
					compare_field("entry_count",  want.entry_count,  entry_count);
					compare_field("selected",     want.selected,     selected);
				end
				results_seen++;
				// draw the stall ahead of the next result
				if (recv_burst > 0) begin
					recv_burst--;
					recv_wait = 0;
				end else begin
					recv_wait = $urandom_range(0, 15);
					if ($urandom_range(0, 39) == 0)
						recv_burst = $urandom_range(20, 60);
				end
				// once per run, back the unit up while the driver keeps offering
				if (results_seen == PRESSURE_AT)
					hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no handshake happens for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles + 1 >= IDLE_LIMIT) begin
					$display("interval_table_lookup_unit test failed");
					$finish;
				end
			end
		end
	end

endmodule
